[hw/rtl/sscd_pkg.sv]
// Shared types, constants and the event transition table for the smoke-sensor
// mode machine. Used by every module under hw/rtl; depends on nothing.
package sscd_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int LIMIT_BITS  = 12;
  localparam int TICKS_BITS  = 4;
  localparam int STATUS_BITS = 3;
  localparam int CIDX_BITS   = 2;
  localparam int CDATA_BITS  = 12;
  localparam int IN_BYTES    = (2 + SAMPLE_BITS + 7) / 8;
  localparam int OUT_BYTES   = (STATUS_BITS + SAMPLE_BITS + 7) / 8;

  localparam logic [CIDX_BITS-1:0] REG_CALI_LIMIT   = 2'd0;
  localparam logic [CIDX_BITS-1:0] REG_CALI_TICKS   = 2'd1;
  localparam logic [CIDX_BITS-1:0] REG_DANGER_LEVEL = 2'd2;

  localparam logic [LIMIT_BITS-1:0] CALI_LIMIT_RST   = 12'd200;
  localparam logic [TICKS_BITS-1:0] CALI_TICKS_RST   = 4'd5;
  localparam logic [LIMIT_BITS-1:0] DANGER_LEVEL_RST = 12'd1000;

  localparam logic [1:0] DETECT_EDGE = 2'd2;
  localparam logic [1:0] DETECT_MAX  = 2'd3;
  localparam logic [TICKS_BITS-1:0] CALI_MAX = 4'd15;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_EVENT  = 1'b1;

  localparam logic [1:0] EV_START = 2'd0;
  localparam logic [1:0] EV_NEXT  = 2'd1;
  localparam logic [1:0] EV_PREV  = 2'd2;
  localparam logic [1:0] EV_STOP  = 2'd3;

  localparam logic [STATUS_BITS-1:0] ST_IDLE   = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_CALI   = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_DETECT = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_DANGER = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_SAFE   = 3'd4;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_CALI   = 4'b0010,
    MODE_DETECT = 4'b0100,
    MODE_RESULT = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [LIMIT_BITS-1:0] cali_limit;
    logic [TICKS_BITS-1:0] cali_ticks;
    logic [LIMIT_BITS-1:0] danger_level;
  } cfg_t;

  typedef struct packed {
    logic                   emit;
    logic [STATUS_BITS-1:0] status;
    logic [SAMPLE_BITS-1:0] value;
  } res_t;

  typedef struct packed {
    logic   hit;
    mode_t  mode;
  } trans_t;

  function automatic trans_t next_mode(input mode_t mode, input logic [1:0] ev);
    trans_t t;
    t.hit  = 1'b1;
    t.mode = mode;
    unique case (mode)
      MODE_IDLE: begin
        if (ev == EV_START) t.mode = MODE_CALI;
        else t.hit = 1'b0;
      end
      MODE_CALI: begin
        if (ev == EV_NEXT) t.mode = MODE_DETECT;
        else if (ev == EV_STOP) t.mode = MODE_IDLE;
        else t.hit = 1'b0;
      end
      MODE_DETECT: begin
        if (ev == EV_NEXT) t.mode = MODE_RESULT;
        else if (ev == EV_PREV) t.mode = MODE_CALI;
        else if (ev == EV_STOP) t.mode = MODE_IDLE;
        else t.hit = 1'b0;
      end
      MODE_RESULT: begin
        if (ev == EV_PREV) t.mode = MODE_DETECT;
        else if (ev == EV_STOP) t.mode = MODE_IDLE;
        else t.hit = 1'b0;
      end
      default: t.hit = 1'b0;
    endcase
    return t;
  endfunction

endpackage

[hw/rtl/smoke_sensor_calibrate_detect_fsm_top.sv]
// Top level of the smoke-sensor mode machine: input item register, decision
// core, result register. Depends on sscd_pkg, sscd_cfg and sscd_core.
//
//  channel | dir | handshake                 | payload
//  s_axis  | in  | s_tvalid / s_tready       | tuser: req_type; tdata: event_code, sample
//  m_axis  | out | m_tvalid / m_tready       | tdata: status, value
//  cfg     | in  | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One item per cycle while the result is not stalled; an item waits in the input
// register, and its report, if any, is loaded into the result register as the item leaves.
// Reset clears the mode machine, counters and valid flags and loads the config defaults.
// A stalled result holds the input register; s_tready stays high while the
// input register is empty or is draining in that cycle.
module smoke_sensor_calibrate_detect_fsm_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [8*sscd_pkg::IN_BYTES-1:0]     s_tdata,   // event_code[1:0], sample[13:2], zeros
  input  logic                                s_tuser,   // req_type[0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [8*sscd_pkg::OUT_BYTES-1:0]    m_tdata,   // status[2:0], value[14:3], zeros
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sscd_pkg::CIDX_BITS-1:0]      cfg_index,
  input  logic [sscd_pkg::CDATA_BITS-1:0]     cfg_data
);

  sscd_pkg::cfg_t                   cfg;
  sscd_pkg::res_t                   res;
  logic                             in_valid;
  logic                             in_req;
  logic [1:0]                       in_event;
  logic [sscd_pkg::SAMPLE_BITS-1:0] in_sample;
  logic                             take;
  logic [sscd_pkg::STATUS_BITS-1:0] out_status;
  logic [sscd_pkg::SAMPLE_BITS-1:0] out_value;

  sscd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sscd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .req_type   (in_req),
    .event_code (in_event),
    .sample     (in_sample),
    .cfg        (cfg),
    .res        (res)
  );

  assign take     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req    <= s_tuser;
      in_event  <= s_tdata[1:0];
      in_sample <= s_tdata[2 +: sscd_pkg::SAMPLE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= take && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.emit) begin
      out_status <= res.status;
      out_value  <= res.value;
    end
  end

  assign m_tdata = {{(8*sscd_pkg::OUT_BYTES - sscd_pkg::STATUS_BITS
                      - sscd_pkg::SAMPLE_BITS){1'b0}}, out_value, out_status};

  assert property (@(posedge clk) disable iff (rst)
    in_valid && m_tvalid && !m_tready |-> !s_tready && !take)
    else $error("input register drained into a stalled result");

  assert property (@(posedge clk) disable iff (rst)
    take && res.emit |=> m_tvalid)
    else $error("report lost");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_status <= sscd_pkg::ST_SAFE)
    else $error("status out of range");

endmodule

[hw/rtl/sscd_cfg.sv]
// Configuration register file: calibration limit, calibration tick count and
// danger level. Depends on sscd_pkg.
module sscd_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sscd_pkg::CIDX_BITS-1:0] cfg_index,
  input  logic [sscd_pkg::CDATA_BITS-1:0] cfg_data,
  output sscd_pkg::cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cali_limit   <= sscd_pkg::CALI_LIMIT_RST;
      cfg.cali_ticks   <= sscd_pkg::CALI_TICKS_RST;
      cfg.danger_level <= sscd_pkg::DANGER_LEVEL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sscd_pkg::REG_CALI_LIMIT:   cfg.cali_limit   <= cfg_data;
        sscd_pkg::REG_CALI_TICKS:   cfg.cali_ticks   <= cfg_data[sscd_pkg::TICKS_BITS-1:0];
        sscd_pkg::REG_DANGER_LEVEL: cfg.danger_level <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/sscd_core.sv]
// Mode machine state and the per-item decision logic: event transitions and
// sample handling. Depends on sscd_pkg.
module sscd_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             take,
  input  logic                             req_type,
  input  logic [1:0]                       event_code,
  input  logic [sscd_pkg::SAMPLE_BITS-1:0] sample,
  input  sscd_pkg::cfg_t                   cfg,
  output sscd_pkg::res_t                   res
);

  sscd_pkg::mode_t                 mode, mode_next;
  logic [sscd_pkg::TICKS_BITS-1:0] cali_count, cali_count_next, cali_inc;
  logic [1:0]                      detect_count, detect_count_next, detect_inc;
  logic                            danger_flag, danger_flag_next;
  sscd_pkg::trans_t                trans;

  always_comb begin
    trans    = sscd_pkg::next_mode(mode, event_code);
    cali_inc = (cali_count == sscd_pkg::CALI_MAX) ? cali_count
                                                  : cali_count + 1'b1;
    detect_inc = (detect_count == sscd_pkg::DETECT_MAX) ? detect_count
                                                        : detect_count + 1'b1;
    mode_next         = mode;
    cali_count_next   = cali_count;
    detect_count_next = detect_count;
    danger_flag_next  = danger_flag;
    res.emit   = 1'b0;
    res.status = sscd_pkg::ST_IDLE;
    res.value  = sample;
    if (req_type == sscd_pkg::REQ_EVENT) begin
      if (trans.hit) mode_next = trans.mode;
    end else begin
      unique case (mode)
        sscd_pkg::MODE_IDLE: begin
          cali_count_next   = '0;
          detect_count_next = '0;
          danger_flag_next  = 1'b0;
          res.emit   = 1'b1;
          res.status = sscd_pkg::ST_IDLE;
        end
        sscd_pkg::MODE_CALI: begin
          detect_count_next = '0;
          if (sample > cfg.cali_limit) begin
            cali_count_next = '0;
          end else if (cali_inc > cfg.cali_ticks) begin
            cali_count_next = '0;
            mode_next       = sscd_pkg::MODE_DETECT;
          end else begin
            cali_count_next = cali_inc;
            res.emit   = 1'b1;
            res.status = sscd_pkg::ST_CALI;
          end
        end
        sscd_pkg::MODE_DETECT: begin
          if (detect_inc > sscd_pkg::DETECT_EDGE && sample < cfg.danger_level) begin
            danger_flag_next  = 1'b0;
            detect_count_next = '0;
            mode_next         = sscd_pkg::MODE_RESULT;
          end else if (detect_inc < sscd_pkg::DETECT_EDGE &&
                       sample > cfg.danger_level) begin
            danger_flag_next  = 1'b1;
            detect_count_next = '0;
            mode_next         = sscd_pkg::MODE_RESULT;
          end else begin
            detect_count_next = detect_inc;
            res.emit   = 1'b1;
            res.status = sscd_pkg::ST_DETECT;
          end
        end
        sscd_pkg::MODE_RESULT: begin
          res.emit   = 1'b1;
          res.status = danger_flag ? sscd_pkg::ST_DANGER : sscd_pkg::ST_SAFE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= sscd_pkg::MODE_IDLE;
      cali_count   <= '0;
      detect_count <= '0;
      danger_flag  <= 1'b0;
    end else if (take) begin
      mode         <= mode_next;
      cali_count   <= cali_count_next;
      detect_count <= detect_count_next;
      danger_flag  <= danger_flag_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    take && req_type == sscd_pkg::REQ_EVENT |-> !res.emit)
    else $error("event produced a result");

  assert property (@(posedge clk) disable iff (rst)
    mode != sscd_pkg::MODE_DETECT |=> detect_count == '0 || mode == sscd_pkg::MODE_DETECT
      || $stable(detect_count))
    else $error("detect count changed outside detect mode");

  assert property (@(posedge clk) disable iff (rst)
    take && req_type == sscd_pkg::REQ_SAMPLE && mode == sscd_pkg::MODE_RESULT
      |-> res.emit)
    else $error("result mode tick gave no report");

endmodule

[verif/smoke_sensor_calibrate_detect_fsm_top_tb.sv]
// Self-checking testbench for smoke_sensor_calibrate_detect_fsm_top: drives items
// and register writes, predicts each status report and compares it on the output.
// Depends on sscd_pkg and the RTL under hw/rtl.
module smoke_sensor_calibrate_detect_fsm_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [sscd_pkg::STATUS_BITS-1:0] status;
    logic [sscd_pkg::SAMPLE_BITS-1:0] value;
  } report_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                s_tvalid = 1'b0;
  logic                                s_tready;
  logic [8*sscd_pkg::IN_BYTES-1:0]     s_tdata = '0;
  logic                                s_tuser = 1'b0;
  logic                                m_tvalid;
  logic                                m_tready = 1'b0;
  logic [8*sscd_pkg::OUT_BYTES-1:0]    m_tdata;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [sscd_pkg::CIDX_BITS-1:0]      cfg_index = '0;
  logic [sscd_pkg::CDATA_BITS-1:0]     cfg_data = '0;

  // mirror of the mode machine
  sscd_pkg::mode_t                     fsm_mode = sscd_pkg::MODE_IDLE;
  logic [sscd_pkg::TICKS_BITS-1:0]     cali_cnt = '0;
  logic [1:0]                          det_cnt = '0;
  logic                                danger_seen = 1'b0;
  logic [sscd_pkg::LIMIT_BITS-1:0]     lim_cali = sscd_pkg::CALI_LIMIT_RST;
  logic [sscd_pkg::TICKS_BITS-1:0]     ticks_cali = sscd_pkg::CALI_TICKS_RST;
  logic [sscd_pkg::LIMIT_BITS-1:0]     lvl_danger = sscd_pkg::DANGER_LEVEL_RST;

  report_t pending_reports[$];
  int      err_count = 0;
  int      hold_left = 0;
  bit      steady = 1'b0;

  smoke_sensor_calibrate_detect_fsm_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5ns clk = ~clk;

  initial begin
    #2ms;
    $display("FAIL smoke_sensor_calibrate_detect_fsm_top");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic void push_report(input logic [sscd_pkg::STATUS_BITS-1:0] st,
                                      input logic [sscd_pkg::SAMPLE_BITS-1:0] val);
    report_t r;
    r.status = st;
    r.value  = val;
    pending_reports.push_back(r);
  endfunction

  function automatic void predict_report(input logic req, input logic [1:0] ev,
                                         input logic [sscd_pkg::SAMPLE_BITS-1:0] smp);
    if (req == sscd_pkg::REQ_EVENT) begin
      case (fsm_mode)
        sscd_pkg::MODE_IDLE: begin
          if (ev == sscd_pkg::EV_START) fsm_mode = sscd_pkg::MODE_CALI;
        end
        sscd_pkg::MODE_CALI: begin
          if (ev == sscd_pkg::EV_NEXT) fsm_mode = sscd_pkg::MODE_DETECT;
          else if (ev == sscd_pkg::EV_STOP) fsm_mode = sscd_pkg::MODE_IDLE;
        end
        sscd_pkg::MODE_DETECT: begin
          if (ev == sscd_pkg::EV_NEXT) fsm_mode = sscd_pkg::MODE_RESULT;
          else if (ev == sscd_pkg::EV_PREV) fsm_mode = sscd_pkg::MODE_CALI;
          else if (ev == sscd_pkg::EV_STOP) fsm_mode = sscd_pkg::MODE_IDLE;
        end
        default: begin
          if (ev == sscd_pkg::EV_PREV) fsm_mode = sscd_pkg::MODE_DETECT;
          else if (ev == sscd_pkg::EV_STOP) fsm_mode = sscd_pkg::MODE_IDLE;
        end
      endcase
      return;
    end
    case (fsm_mode)
      sscd_pkg::MODE_IDLE: begin
        danger_seen = 1'b0;
        cali_cnt = '0;
        det_cnt = '0;
        push_report(sscd_pkg::ST_IDLE, smp);
      end
      sscd_pkg::MODE_CALI: begin
        if (cali_cnt != sscd_pkg::CALI_MAX) cali_cnt++;
        det_cnt = '0;
        if (smp > lim_cali) begin
          cali_cnt = '0;
        end else if (cali_cnt > ticks_cali) begin
          cali_cnt = '0;
          fsm_mode = sscd_pkg::MODE_DETECT;
        end else begin
          push_report(sscd_pkg::ST_CALI, smp);
        end
      end
      sscd_pkg::MODE_DETECT: begin
        if (det_cnt != sscd_pkg::DETECT_MAX) det_cnt++;
        if (det_cnt > sscd_pkg::DETECT_EDGE && smp < lvl_danger) begin
          danger_seen = 1'b0;
          det_cnt = '0;
          fsm_mode = sscd_pkg::MODE_RESULT;
        end else if (det_cnt < sscd_pkg::DETECT_EDGE && smp > lvl_danger) begin
          danger_seen = 1'b1;
          det_cnt = '0;
          fsm_mode = sscd_pkg::MODE_RESULT;
        end else begin
          push_report(sscd_pkg::ST_DETECT, smp);
        end
      end
      default: push_report(danger_seen ? sscd_pkg::ST_DANGER : sscd_pkg::ST_SAFE, smp);
    endcase
  endfunction

  task automatic check_report(input logic [sscd_pkg::STATUS_BITS-1:0] st,
                              input logic [sscd_pkg::SAMPLE_BITS-1:0] val);
    report_t want;
    if (pending_reports.size() == 0) begin
      flag_mismatch($sformatf("unexpected report status %0d value %0d", st, val));
      return;
    end
    want = pending_reports.pop_front();
    if (st !== want.status)
      flag_mismatch($sformatf("status %0d, want %0d", st, want.status));
    if (val !== want.value)
      flag_mismatch($sformatf("value %0d, want %0d", val, want.value));
  endtask

  // accept reports, stall at random or for a requested hold-off
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      check_report(m_tdata[2:0], m_tdata[14:3]);
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= 19);
    end
  end

  task automatic send_item(input logic req, input logic [1:0] ev,
                           input logic [sscd_pkg::SAMPLE_BITS-1:0] smp);
    while (!steady && $urandom_range(99) < 19) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {2'b00, smp, ev};
    do @(posedge clk); while (!s_tready);
    predict_report(req, ev, smp);
  endtask

  task automatic write_reg(input logic [sscd_pkg::CIDX_BITS-1:0] idx,
                           input logic [sscd_pkg::CDATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      sscd_pkg::REG_CALI_LIMIT:   lim_cali = data;
      sscd_pkg::REG_CALI_TICKS:   ticks_cali = data[sscd_pkg::TICKS_BITS-1:0];
      sscd_pkg::REG_DANGER_LEVEL: lvl_danger = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // wait for all reports, then let items with no report leave the pipeline
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    logic                             req;
    logic [1:0]                       ev;
    logic [sscd_pkg::SAMPLE_BITS-1:0] smp;
    int                               pick;
    repeat (count) begin
      pick = $urandom_range(99);
      ev   = 2'($urandom_range(3));
      smp  = 12'($urandom_range(4095));
      req  = sscd_pkg::REQ_SAMPLE;
      if (fsm_mode == sscd_pkg::MODE_IDLE) begin
        if (pick < 30) begin
          req = sscd_pkg::REQ_EVENT;
          if (pick < 22) ev = sscd_pkg::EV_START;
        end
      end else if (pick < 12) begin
        req = sscd_pkg::REQ_EVENT;
      end else if (fsm_mode == sscd_pkg::MODE_CALI) begin
        if (pick < 95) smp = 12'($urandom_range(lim_cali));
      end else if (fsm_mode == sscd_pkg::MODE_DETECT) begin
        case (pick % 4)
          0: smp = lvl_danger;
          1: if (lvl_danger != 0) smp = 12'($urandom_range(lvl_danger - 1));
          2: if (lvl_danger != 4095) smp = 12'($urandom_range(4095, lvl_danger + 1));
          default: ;
        endcase
      end
      send_item(req, ev, smp);
    end
  endtask

  task automatic test_directed();
    int i;
    send_item(sscd_pkg::REQ_SAMPLE, sscd_pkg::EV_STOP, 12'd0);
    send_item(sscd_pkg::REQ_SAMPLE, sscd_pkg::EV_NEXT, 12'hfff);
    send_item(sscd_pkg::REQ_EVENT, sscd_pkg::EV_NEXT, 12'hfff);
    send_item(sscd_pkg::REQ_EVENT, sscd_pkg::EV_PREV, 12'h5a5);
    send_item(sscd_pkg::REQ_EVENT, sscd_pkg::EV_STOP, 12'ha5a);
    send_item(sscd_pkg::REQ_EVENT, sscd_pkg::EV_START, 12'd0);
    send_item(sscd_pkg::REQ_EVENT, sscd_pkg::EV_START, 12'd7);
    send_item(sscd_pkg::REQ_EVENT, sscd_pkg::EV_PREV, 12'd9);
    // noisy sample restarts the count, sample at the limit counts as quiet
    send_item(sscd_pkg::REQ_SAMPLE, sscd_pkg::EV_PREV, 12'hfff);
    send_item(sscd_pkg::REQ_SAMPLE, sscd_pkg::EV_STOP, 12'd200);
    for (i = 0; i < 5; i++) begin
      send_item(sscd_pkg::REQ_SAMPLE, i[1:0], 12'($urandom_range(200)));
    end
    send_item(sscd_pkg::REQ_EVENT, sscd_pkg::EV_PREV, 12'd1);
    send_item(sscd_pkg::REQ_EVENT, sscd_pkg::EV_NEXT, 12'd1);
    send_item(sscd_pkg::REQ_SAMPLE, sscd_pkg::EV_START, 12'hfff);
    send_item(sscd_pkg::REQ_SAMPLE, sscd_pkg::EV_NEXT, 12'd5);
    send_item(sscd_pkg::REQ_EVENT, sscd_pkg::EV_NEXT, 12'd0);
    send_item(sscd_pkg::REQ_EVENT, sscd_pkg::EV_PREV, 12'd0);
    // equal to the level gives no verdict; counter saturates
    for (i = 0; i < 4; i++) send_item(sscd_pkg::REQ_SAMPLE, sscd_pkg::EV_START, 12'd1000);
    send_item(sscd_pkg::REQ_SAMPLE, sscd_pkg::EV_START, 12'd999);
    send_item(sscd_pkg::REQ_SAMPLE, sscd_pkg::EV_STOP, 12'd3);
    send_item(sscd_pkg::REQ_EVENT, sscd_pkg::EV_STOP, 12'd0);
    drain();
  endtask

  task automatic test_backpressure();
    int i;
    hold_left = 80;
    send_item(sscd_pkg::REQ_EVENT, sscd_pkg::EV_STOP, 12'd0);
    for (i = 0; i < 24; i++) begin
      send_item(sscd_pkg::REQ_SAMPLE, sscd_pkg::EV_START, 12'($urandom_range(4095)));
    end
    drain();
  endtask

  task automatic test_config_sweep();
    logic [sscd_pkg::LIMIT_BITS-1:0] lims[7]   = '{12'hfff, 12'd0, 12'd200, 12'd300,
                                                   12'd0, 12'd0, 12'd0};
    logic [sscd_pkg::TICKS_BITS-1:0] ticks[7]  = '{4'd14, 4'd1, 4'd15, 4'd0,
                                                   4'd0, 4'd0, 4'd0};
    logic [sscd_pkg::LIMIT_BITS-1:0] levels[7] = '{12'hfff, 12'd0, 12'd1000, 12'd2048,
                                                   12'd0, 12'd0, 12'd0};
    int p;
    for (p = 0; p < 7; p++) begin
      if (p >= 4) begin
        lims[p]   = 12'($urandom_range(4095));
        ticks[p]  = 4'($urandom_range(1, 14));
        levels[p] = 12'($urandom_range(4095));
      end
      write_reg(sscd_pkg::REG_DANGER_LEVEL, levels[p]);
      write_reg(sscd_pkg::REG_CALI_LIMIT, lims[p]);
      write_reg(sscd_pkg::REG_CALI_TICKS, {8'($urandom_range(255)), ticks[p]});
      // index past the register list is ignored
      if (p == 3) write_reg(2'd3, 12'($urandom_range(4095)));
      send_random(150);
      drain();
    end
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    write_reg(sscd_pkg::REG_CALI_LIMIT, 12'd1500);
    write_reg(sscd_pkg::REG_CALI_TICKS, 12'd3);
    write_reg(sscd_pkg::REG_DANGER_LEVEL, 12'd2500);
    send_random(150);
    drain();
    steady = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_config_sweep();
    test_steady_stream();
    if (err_count == 0) begin
      $display("PASS smoke_sensor_calibrate_detect_fsm_top");
    end else begin
      $display("FAIL smoke_sensor_calibrate_detect_fsm_top");
    end
    $finish;
  end

endmodule
